// ----- hw/rtl/bda_pkg.sv -----
// Shared types, constants and helpers for the button debounce / autorepeat unit.
package bda_pkg;

    localparam int TIME_WIDTH = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
    localparam int ADDR_W     = 5;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [CFG_W-1:0]      t_cfg_val;

    typedef enum logic [1:0] {
        ACT_SINGLE = 2'd0,
        ACT_REPEAT = 2'd1,
        ACT_CONT   = 2'd2,
        ACT_ACCEL  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_IMPULSE  = 3'd1,
        REG_FSTART   = 3'd2,
        REG_FLIMIT   = 3'd3,
        REG_FFLOOR   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_cfg_val debounce_ticks;
        t_cfg_val impulse_ticks;
        t_cfg_val fasten_start_ticks;
        t_cfg_val fasten_limit_ticks;
        t_cfg_val fasten_floor_ticks;
    } t_cfg;

    typedef struct packed {
        logic released;
        logic held;
        logic fire;
    } t_result;

    function automatic t_time sat_inc(input t_time v);
        return (v == TIME_MAX) ? v : v + t_time'(1);
    endfunction

    function automatic t_cfg_val at_least_one(input t_cfg_val v);
        return (v == '0) ? t_cfg_val'(1) : v;
    endfunction

endpackage

// ----- hw/rtl/button_debounce_autorepeat_unit.sv -----
// Top level: stream ports, config port and result register.
//
// Each input request is one sample tick carrying the raw button level and the
// reading mode; each produces exactly one result (fire, held, released). The
// unit accepts one request per clock while the result side takes data: the tick
// state is updated at accept and the result is registered at the same edge and
// offered in the next cycle. A pending result only blocks input while the
// downstream stalls. The user must write configuration registers over APB only
// while no tick is in flight; the unit itself does not enforce this.
module button_debounce_autorepeat_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [0] button_level, [2:1] action
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [0] fire, [1] held, [2] released
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bda_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bda_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    step;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    bda_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bda_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_level  (s_axis_tdata[0]),
        .i_action (t_action'(s_axis_tdata[2:1])),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.released, r_out.held, r_out.fire};

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_valid_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared without a request");

    a_release_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[1]))
        else $error("released while still held");

    a_fire_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("fire without held");
`endif

endmodule

// ----- hw/rtl/bda_cfg_regs.sv -----
// APB configuration register file for the debounce / autorepeat unit.
module bda_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bda_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output bda_pkg::t_cfg              o_cfg
);
    import bda_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= t_cfg_val'(20);
            r_cfg.impulse_ticks      <= t_cfg_val'(250);
            r_cfg.fasten_start_ticks <= t_cfg_val'(2000);
            r_cfg.fasten_limit_ticks <= t_cfg_val'(100);
            r_cfg.fasten_floor_ticks <= t_cfg_val'(50);
        end else if (wr_en) begin
            unique case (idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks     <= pwdata[CFG_W-1:0];
                REG_IMPULSE:  r_cfg.impulse_ticks      <= pwdata[CFG_W-1:0];
                REG_FSTART:   r_cfg.fasten_start_ticks <= pwdata[CFG_W-1:0];
                REG_FLIMIT:   r_cfg.fasten_limit_ticks <= pwdata[CFG_W-1:0];
                REG_FFLOOR:   r_cfg.fasten_floor_ticks <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DEBOUNCE: prdata = 32'(r_cfg.debounce_ticks);
            REG_IMPULSE:  prdata = 32'(r_cfg.impulse_ticks);
            REG_FSTART:   prdata = 32'(r_cfg.fasten_start_ticks);
            REG_FLIMIT:   prdata = 32'(r_cfg.fasten_limit_ticks);
            REG_FFLOOR:   prdata = 32'(r_cfg.fasten_floor_ticks);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/bda_core.sv -----
// Per-tick debounce and firing-mode state update.
module bda_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  bda_pkg::t_action i_action,
    input  bda_pkg::t_cfg    i_cfg,
    output bda_pkg::t_result o_result
);
    import bda_pkg::*;

    logic     r_deb, n_deb;
    t_time    r_since, n_since;
    logic [3:0] r_mode_active, n_mode_active;
    logic     r_switch, n_switch;
    t_time    r_rep_cnt, n_rep_cnt;
    logic     r_rep_phase, n_rep_phase;
    t_time    r_acc_cnt, n_acc_cnt;
    t_cfg_val r_acc_int, n_acc_int;

    logic [3:0] mode_bit;
    t_cfg_val   acc_next;
    logic       fire;

    assign mode_bit = 4'b0001 << i_action;
    assign acc_next = r_acc_int - (r_acc_int >> 2);

    always_comb begin
        n_deb         = r_deb;
        n_since       = r_since;
        n_mode_active = r_mode_active;
        n_switch      = r_switch;
        n_rep_cnt     = r_rep_cnt;
        n_rep_phase   = r_rep_phase;
        n_acc_cnt     = r_acc_cnt;
        n_acc_int     = r_acc_int;
        fire          = 1'b0;

        // press sets held at once; held lasts while pressed and at least debounce_ticks past press start
        if (i_level) begin
            if (!r_deb) begin
                n_deb   = 1'b1;
                n_since = '0;
            end else begin
                n_since = sat_inc(r_since);
            end
        end else if (r_deb) begin
            n_since = sat_inc(r_since);
            n_deb   = CMP_W'(n_since) <= CMP_W'(i_cfg.debounce_ticks);
        end

        // a different engaged mode: drop it and hold off firing
        if ((r_mode_active & ~mode_bit) != 4'b0) begin
            n_mode_active = r_mode_active & mode_bit;
            n_switch      = 1'b1;
        end

        if (n_switch) begin
            if (i_action == ACT_SINGLE) begin
                n_mode_active = mode_bit;
                n_switch      = 1'b0;
            end else if (!n_deb) begin
                n_switch = 1'b0;
            end
        end else if (!n_deb) begin
            n_mode_active = 4'b0;
        end else if ((n_mode_active & mode_bit) == 4'b0) begin
            n_mode_active = mode_bit;
            fire          = 1'b1;
            n_rep_cnt     = '0;
            n_acc_cnt     = '0;
            n_acc_int     = at_least_one(i_cfg.fasten_start_ticks);
        end else begin
            unique case (i_action)
                ACT_REPEAT: begin
                    n_rep_cnt = sat_inc(r_rep_cnt);
                    if (CMP_W'(n_rep_cnt) >= CMP_W'(at_least_one(i_cfg.impulse_ticks))) begin
                        n_rep_cnt   = '0;
                        n_rep_phase = !r_rep_phase;
                        fire        = 1'b1;
                    end
                end
                ACT_CONT: fire = 1'b1;
                ACT_ACCEL: begin
                    n_acc_cnt = sat_inc(r_acc_cnt);
                    if (CMP_W'(n_acc_cnt) >= CMP_W'(at_least_one(r_acc_int))) begin
                        n_acc_cnt = '0;
                        if (acc_next < i_cfg.fasten_limit_ticks)
                            n_acc_int = at_least_one(i_cfg.fasten_floor_ticks);
                        else
                            n_acc_int = at_least_one(acc_next);
                        fire = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        o_result.fire     = fire;
        o_result.held     = n_deb;
        o_result.released = r_deb && !n_deb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb         <= 1'b0;
            r_since       <= '0;
            r_mode_active <= 4'b0;
            r_switch      <= 1'b0;
            r_rep_cnt     <= '0;
            r_rep_phase   <= 1'b0;
            r_acc_cnt     <= '0;
            r_acc_int     <= '0;
        end else if (i_step) begin
            r_deb         <= n_deb;
            r_since       <= n_since;
            r_mode_active <= n_mode_active;
            r_switch      <= n_switch;
            r_rep_cnt     <= n_rep_cnt;
            r_rep_phase   <= n_rep_phase;
            r_acc_cnt     <= n_acc_cnt;
            r_acc_int     <= n_acc_int;
        end
    end

endmodule
